@@ src/qte_pkg.sv @@
// Shared types, widths and the arctangent step table of the quaternion to Euler converter.
package qte_pkg;

    // Default values of the top level parameters and the arctangent table size.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int ATAN_ENTRIES      = 24;

    // Fixed widths that follow from the Q2.14 input fields.
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int PROD_W    = 32;
    localparam int TERM_W    = 34;
    localparam int VEC_W     = 37;
    localparam int ZW        = 34;
    localparam int MAG_W     = 29;
    localparam int SQ_W      = 58;
    localparam int ROOT_BITS = 29;

    localparam logic signed [TERM_W-1:0] ONE_Q28      = 34'sh0_1000_0000;
    localparam logic signed [ZW-1:0]     QUARTER_TURN = 34'sh0_4000_0000;
    localparam logic [SQ_W-1:0]          ONE_Q56      = 58'h100_0000_0000_0000;

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [ZW-1:0]     ang_t;

    // The five trigonometric terms carried alongside the square root.
    typedef struct packed {
        term_t t0;
        term_t t1;
        term_t t2;
        term_t t3;
        term_t t4;
    } terms_t;

    // Arctangent of 2^-i, with 2^31 standing for pi.
    function automatic ang_t atan_step(input int i);
        ang_t a;
        case (i)
            0:       a = 34'sd536870912;
            1:       a = 34'sd316933406;
            2:       a = 34'sd167458907;
            3:       a = 34'sd85004756;
            4:       a = 34'sd42667331;
            5:       a = 34'sd21354465;
            6:       a = 34'sd10679838;
            7:       a = 34'sd5340245;
            8:       a = 34'sd2670163;
            9:       a = 34'sd1335087;
            10:      a = 34'sd667544;
            11:      a = 34'sd333772;
            12:      a = 34'sd166886;
            13:      a = 34'sd83443;
            14:      a = 34'sd41722;
            15:      a = 34'sd20861;
            16:      a = 34'sd10430;
            17:      a = 34'sd5215;
            18:      a = 34'sd2608;
            19:      a = 34'sd1304;
            20:      a = 34'sd652;
            21:      a = 34'sd326;
            22:      a = 34'sd163;
            23:      a = 34'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ src/qte_cordic.sv @@
// Pipelined vectoring CORDIC lane that turns a vector into its binary angle.
module qte_cordic #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_WIDTH   = qte_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  qte_pkg::term_t              y_in,
    input  qte_pkg::term_t              x_in,
    output logic [qte_pkg::OUT_W-1:0]   angle
);

    qte_pkg::vec_t x_reg    [0:CORDIC_STAGES];
    qte_pkg::vec_t y_reg    [0:CORDIC_STAGES];
    qte_pkg::ang_t z_reg    [0:CORDIC_STAGES];
    logic          zero_reg [0:CORDIC_STAGES];

    qte_pkg::vec_t x_next;
    qte_pkg::vec_t y_next;
    qte_pkg::ang_t z_next;
    logic          zero_next;
    logic [qte_pkg::OUT_W-1:0] angle_next;
    logic [qte_pkg::OUT_W-1:0] angle_reg;

    // Pre-rotation: a vector in the left half plane is turned by a quarter turn.
    always_comb
    begin
        zero_next = (x_in == '0) && (y_in == '0);
        x_next    = qte_pkg::VEC_W'(x_in);
        y_next    = qte_pkg::VEC_W'(y_in);
        z_next    = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next = qte_pkg::VEC_W'(y_in);
                y_next = -qte_pkg::VEC_W'(x_in);
                z_next = qte_pkg::QUARTER_TURN;
            end
            else
            begin
                x_next = -qte_pkg::VEC_W'(y_in);
                y_next = qte_pkg::VEC_W'(x_in);
                z_next = -qte_pkg::QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            zero_reg[0] <= zero_next;
        end
    end

    // One micro-rotation per stage; a zero y counts as negative.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_iter
        qte_pkg::vec_t xs_next;
        qte_pkg::vec_t ys_next;
        qte_pkg::ang_t zs_next;

        always_comb
        begin
            if (y_reg[i] > 0)
            begin
                xs_next = x_reg[i] + (y_reg[i] >>> i);
                ys_next = y_reg[i] - (x_reg[i] >>> i);
                zs_next = z_reg[i] + qte_pkg::atan_step(i);
            end
            else
            begin
                xs_next = x_reg[i] - (y_reg[i] >>> i);
                ys_next = y_reg[i] + (x_reg[i] >>> i);
                zs_next = z_reg[i] - qte_pkg::atan_step(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= xs_next;
                y_reg[i+1]    <= ys_next;
                z_reg[i+1]    <= zs_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Rounding of the angle to ANGLE_WIDTH bits below 32, with wrap-around.
    if (ANGLE_WIDTH >= 32)
    begin : g_full
        logic signed [ANGLE_WIDTH-1:0] r_aw;
        logic signed [63:0]            r_ext;
        always_comb
        begin
            r_aw       = ANGLE_WIDTH'(z_reg[CORDIC_STAGES]);
            r_ext      = 64'(r_aw);
            angle_next = zero_reg[CORDIC_STAGES] ? '0 : r_ext[qte_pkg::OUT_W-1:0];
        end
    end
    else
    begin : g_round
        localparam int SHIFT = 32 - ANGLE_WIDTH;
        logic signed [qte_pkg::ZW:0]   rnd;
        logic signed [qte_pkg::ZW:0]   r;
        logic signed [ANGLE_WIDTH-1:0] r_aw;
        logic signed [63:0]            r_ext;
        always_comb
        begin
            rnd        = (qte_pkg::ZW+1)'(z_reg[CORDIC_STAGES])
                         + ((qte_pkg::ZW+1)'(1) <<< (SHIFT - 1));
            r          = rnd >>> SHIFT;
            r_aw       = r[ANGLE_WIDTH-1:0];
            r_ext      = 64'(r_aw);
            angle_next = zero_reg[CORDIC_STAGES] ? '0 : r_ext[qte_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

@@ src/quaternion_to_euler.sv @@
// Top level of the pipelined quaternion to roll, pitch and yaw converter.
//
// Input channel: in_valid with in_stall; one unit quaternion w, x, y, z in
// signed Q2.14 moves on each transfer. Output channel: out_valid with
// out_stall; roll, pitch and yaw in binary angle units (32768 is pi) move on
// each transfer. Exactly one result leaves for every quaternion taken in.
// Stages: five for input, products, sums, square and one minus the square;
// 29 of the bit-serial square root for pitch; and in each of three CORDIC
// lanes side by side, a pre-rotation, CORDIC_STAGES micro-rotations and a
// rounding stage. Throughput is one transfer per cycle unless stalled.
// Reset clears only the valid bits of the pipeline, so the block comes out
// of reset empty. When the receiver stalls a waiting result, the whole
// pipeline holds and in_stall rises; bubbles still move forward while no
// result waits at the output.
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_WIDTH   = qte_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_w,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_x,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_y,
    input  logic signed [qte_pkg::IN_W-1:0]     quat_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [qte_pkg::OUT_W-1:0]    roll_angle,
    output logic signed [qte_pkg::OUT_W-1:0]    pitch_angle,
    output logic signed [qte_pkg::OUT_W-1:0]    yaw_angle
);

    localparam int LAT = 36 + CORDIC_STAGES;
    localparam int SQRT_LAST = 4 + qte_pkg::ROOT_BITS;

    logic en;
    logic vld_reg [0:LAT-1];

    logic signed [qte_pkg::IN_W-1:0]   w_reg, x_reg, y_reg, z_reg;
    logic signed [qte_pkg::PROD_W-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [qte_pkg::PROD_W-1:0] p_wy_reg, p_zx_reg, p_wz_reg, p_xy_reg;

    qte_pkg::terms_t           terms_next, terms_reg, terms4_reg;
    logic [qte_pkg::MAG_W-1:0] mag_next, mag_reg;
    logic [qte_pkg::SQ_W-1:0]  sq_reg;
    qte_pkg::term_t            t2_raw;

    logic [qte_pkg::SQ_W-1:0] rem_reg  [0:qte_pkg::ROOT_BITS];
    logic [qte_pkg::SQ_W-1:0] root_reg [0:qte_pkg::ROOT_BITS];
    qte_pkg::terms_t          dly_reg  [0:qte_pkg::ROOT_BITS];

    // The whole pipeline advances unless a waiting result is stalled.
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Input register and the nine products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg    <= quat_w;
            x_reg    <= quat_x;
            y_reg    <= quat_y;
            z_reg    <= quat_z;
            p_wx_reg <= w_reg * x_reg;
            p_yz_reg <= y_reg * z_reg;
            p_xx_reg <= x_reg * x_reg;
            p_yy_reg <= y_reg * y_reg;
            p_zz_reg <= z_reg * z_reg;
            p_wy_reg <= w_reg * y_reg;
            p_zx_reg <= z_reg * x_reg;
            p_wz_reg <= w_reg * z_reg;
            p_xy_reg <= x_reg * y_reg;
        end
    end

    // Sums of products, with the pitch sine clamped to plus or minus one.
    always_comb
    begin
        terms_next.t0 = (qte_pkg::TERM_W'(p_wx_reg) + qte_pkg::TERM_W'(p_yz_reg)) <<< 1;
        terms_next.t1 = qte_pkg::ONE_Q28
                        - ((qte_pkg::TERM_W'(p_xx_reg) + qte_pkg::TERM_W'(p_yy_reg)) <<< 1);
        t2_raw        = (qte_pkg::TERM_W'(p_wy_reg) - qte_pkg::TERM_W'(p_zx_reg)) <<< 1;
        terms_next.t3 = (qte_pkg::TERM_W'(p_wz_reg) + qte_pkg::TERM_W'(p_xy_reg)) <<< 1;
        terms_next.t4 = qte_pkg::ONE_Q28
                        - ((qte_pkg::TERM_W'(p_yy_reg) + qte_pkg::TERM_W'(p_zz_reg)) <<< 1);
        if (t2_raw > qte_pkg::ONE_Q28)
        begin
            terms_next.t2 = qte_pkg::ONE_Q28;
        end
        else if (t2_raw < -qte_pkg::ONE_Q28)
        begin
            terms_next.t2 = -qte_pkg::ONE_Q28;
        end
        else
        begin
            terms_next.t2 = t2_raw;
        end
        mag_next = (terms_next.t2 < 0) ? qte_pkg::MAG_W'(-terms_next.t2)
                                       : qte_pkg::MAG_W'(terms_next.t2);
    end

    // Terms register, square of the sine, then one minus the square.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg   <= terms_next;
            mag_reg     <= mag_next;
            terms4_reg  <= terms_reg;
            sq_reg      <= qte_pkg::SQ_W'(mag_reg) * qte_pkg::SQ_W'(mag_reg);
            rem_reg[0]  <= qte_pkg::ONE_Q56 - sq_reg;
            root_reg[0] <= '0;
            dly_reg[0]  <= terms4_reg;
        end
    end

    // Floor square root, one result bit per stage.
    for (genvar k = 0; k < qte_pkg::ROOT_BITS; k++)
    begin : g_sqrt
        localparam logic [qte_pkg::SQ_W-1:0] BIT_K =
            qte_pkg::SQ_W'(1) << (2 * (qte_pkg::ROOT_BITS - 1 - k));
        logic [qte_pkg::SQ_W-1:0] trial;
        logic [qte_pkg::SQ_W-1:0] rem_next;
        logic [qte_pkg::SQ_W-1:0] root_next;

        always_comb
        begin
            trial = root_reg[k] + BIT_K;
            if (rem_reg[k] >= trial)
            begin
                rem_next  = rem_reg[k] - trial;
                root_next = (root_reg[k] >> 1) + BIT_K;
            end
            else
            begin
                rem_next  = rem_reg[k];
                root_next = root_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                dly_reg[k+1]  <= dly_reg[k];
            end
        end
    end

    // Three CORDIC lanes for roll, pitch and yaw.
    qte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .ANGLE_WIDTH   (ANGLE_WIDTH)
    ) u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (dly_reg[qte_pkg::ROOT_BITS].t0),
        .x_in  (dly_reg[qte_pkg::ROOT_BITS].t1),
        .angle (roll_angle)
    );

    qte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .ANGLE_WIDTH   (ANGLE_WIDTH)
    ) u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (dly_reg[qte_pkg::ROOT_BITS].t2),
        .x_in  (qte_pkg::TERM_W'(root_reg[qte_pkg::ROOT_BITS][qte_pkg::MAG_W-1:0])),
        .angle (pitch_angle)
    );

    qte_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .ANGLE_WIDTH   (ANGLE_WIDTH)
    ) u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (dly_reg[qte_pkg::ROOT_BITS].t3),
        .x_in  (dly_reg[qte_pkg::ROOT_BITS].t4),
        .angle (yaw_angle)
    );

    // The input is held back only by a stalled result at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // A stalled result stays valid and its pitch angle stays in place.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pitch_angle)))
        else $error("stalled result changed");

    // The clamped sine never exceeds one in magnitude.
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> ((terms_reg.t2 <= qte_pkg::ONE_Q28)
                        && (terms_reg.t2 >= -qte_pkg::ONE_Q28)))
        else $error("pitch sine out of range");

    // The cosine from the square root never exceeds one.
    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SQRT_LAST] |-> (root_reg[qte_pkg::ROOT_BITS]
                                <= qte_pkg::SQ_W'(qte_pkg::ONE_Q28)))
        else $error("square root out of range");

endmodule

@@ tb/quaternion_to_euler_tb.sv @@
// Self-checking testbench of the quaternion to roll, pitch and yaw converter.
module quaternion_to_euler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES    = qte_pkg::CORDIC_STAGES_DEF;
    localparam int AWIDTH    = qte_pkg::ANGLE_WIDTH_DEF;
    localparam int LATENCY   = 36 + STAGES;
    localparam int MAX_CYCLES = 400000;

    // Expected roll, pitch and yaw of one quaternion.
    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
    } euler_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] roll_angle, pitch_angle, yaw_angle;

    euler_t angles_due[$];
    int     mismatches;
    int     unexpected;
    int     sent;
    int     received;
    int     cycles;

    quaternion_to_euler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Arithmetic shift right that rounds towards minus infinity.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Vectoring arctangent with 2^31 standing for pi.
    function automatic longint vector_angle(longint yv, longint xv);
        longint ang, tmp, nx, ny;
        ang = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                tmp = xv; xv = yv; yv = -tmp; ang = 64'sd1 <<< 30;
            end
            else
            begin
                tmp = xv; xv = -yv; yv = tmp; ang = -(64'sd1 <<< 30);
            end
        end
        for (int i = 0; i < STAGES && i < qte_pkg::ATAN_ENTRIES; i++)
        begin
            if (yv > 0)
            begin
                nx = xv + floor_shift(yv, i);
                ny = yv - floor_shift(xv, i);
                ang += longint'(qte_pkg::atan_step(i));
            end
            else
            begin
                nx = xv - floor_shift(yv, i);
                ny = yv + floor_shift(xv, i);
                ang -= longint'(qte_pkg::atan_step(i));
            end
            xv = nx;
            yv = ny;
        end
        return ang;
    endfunction

    // Round the internal angle to the output width and sign extend it.
    function automatic logic [15:0] round_angle(longint a);
        longint r;
        logic [63:0] u;
        r = (a + (64'sd1 <<< (31 - AWIDTH))) >>> (32 - AWIDTH);
        u = r;
        return u[15:0];
    endfunction

    // Floor square root of a non-negative 64-bit value.
    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Euler angles of one quaternion, as the block should compute them.
    function automatic euler_t quat_to_euler(logic signed [15:0] qw, logic signed [15:0] qx,
                                             logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, xx, yy, zz, t0, t1, t2, t3, t4, c, one;
        euler_t e;
        w = qw; x = qx; y = qy; z = qz;
        one = 64'sd1 <<< 28;
        xx = x * x; yy = y * y; zz = z * z;
        t0 = 2 * (w * x + y * z);
        t1 = one - 2 * (xx + yy);
        t2 = 2 * (w * y - z * x);
        t3 = 2 * (w * z + x * y);
        t4 = one - 2 * (yy + zz);
        if (t2 > one)
            t2 = one;
        if (t2 < -one)
            t2 = -one;
        c = floor_sqrt((64'sd1 <<< 56) - t2 * t2);
        e.roll  = round_angle(vector_angle(t0, t1));
        e.pitch = round_angle(vector_angle(t2, c));
        e.yaw   = round_angle(vector_angle(t3, t4));
        return e;
    endfunction

    // Random gap length: mostly none or short, now and then long.
    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Send one quaternion and record its expected angles on transfer.
    // Valid is dropped only for a gap, so back-to-back calls keep it high.
    task automatic send_quat(logic signed [15:0] qw, logic signed [15:0] qx,
                             logic signed [15:0] qy, logic signed [15:0] qz, bit gaps);
        int g;
        g = gaps ? gap_length() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        angles_due.push_back(quat_to_euler(qw, qx, qy, qz));
        sent++;
    endtask

    // Random unit quaternion of any orientation, in Q2.14.
    task automatic send_unit_quat(bit gaps);
        real a, b, c, d, n;
        a = $itor($signed($urandom_range(0, 65534)) - 32767);
        b = $itor($signed($urandom_range(0, 65534)) - 32767);
        c = $itor($signed($urandom_range(0, 65534)) - 32767);
        d = $itor($signed($urandom_range(0, 65534)) - 32767);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1.0; n = 1.0;
        end
        send_quat(16'($rtoi(16384.0 * a / n)), 16'($rtoi(16384.0 * b / n)),
                  16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n)), gaps);
    endtask

    // Extremes, zero vector, axis rotations and gimbal lock.
    task automatic test_directed();
        send_quat(0, 0, 0, 0, 0);
        send_quat(16384, 0, 0, 0, 0);
        send_quat(-16384, 0, 0, 0, 0);
        send_quat(0, 16384, 0, 0, 0);
        send_quat(0, 0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384, 0);
        send_quat(11585, 11585, 0, 0, 0);
        send_quat(11585, 0, 11585, 0, 0);
        send_quat(11585, 0, -11585, 0, 0);
        send_quat(11585, 0, 0, 11585, 0);
        send_quat(11585, 0, 0, -11585, 0);
        send_quat(8192, 8192, 8192, 8192, 0);
        send_quat(8192, -8192, 8192, -8192, 0);
        send_quat(32767, 32767, 32767, 32767, 0);
        send_quat(-32768, -32768, -32768, -32768, 0);
        send_quat(32767, -32768, 32767, -32768, 0);
        send_quat(-32768, 32767, 32767, 32767, 0);
        send_quat(0, 16384, 0, 1, 0);
        send_quat(0, 16384, 0, -1, 0);
        send_quat(0, 0, 16384, 16384, 0);
        send_quat(-1, -1, -1, -1, 0);
        send_quat(1, 0, 0, 0, 0);
        send_quat(0, 16384, 16384, 0, 0);
    endtask

    // Mostly unit quaternions, with raw bit patterns as noise.
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                send_unit_quat(1);
            else
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1);
        end
    endtask

    // Back-to-back transfers with no gaps on the sending side.
    task automatic test_burst(int count);
        for (int i = 0; i < count; i++)
            send_unit_quat(0);
    endtask

    // Receiver stall pattern; some stretches never stall.
    initial
    begin
        int g;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = gap_length();
            out_stall <= (g != 0);
            repeat (g > 0 ? g : $urandom_range(1, 20)) @(posedge clk);
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            received++;
            if (angles_due.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result: roll %0d pitch %0d yaw %0d",
                             roll_angle, pitch_angle, yaw_angle);
            end
            else
            begin
                e = angles_due.pop_front();
                if (e.roll !== roll_angle || e.pitch !== pitch_angle
                    || e.yaw !== yaw_angle)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                                 $signed(e.roll), roll_angle, $signed(e.pitch),
                                 pitch_angle, $signed(e.yaw), yaw_angle);
                end
            end
        end
    end

    // Cycle limit on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("quaternion_to_euler_tb: FAIL");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        mismatches = 0; unexpected = 0; sent = 0; received = 0; cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(750);
        test_burst(200);
        in_valid <= 1'b0;
        while (angles_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d quaternions, checked %0d results", sent, received);
        $display("covered axis turns, gimbal lock, zero and extreme inputs, random rotations");
        if (mismatches == 0 && unexpected == 0 && angles_due.size() == 0)
            $display("quaternion_to_euler_tb: PASS");
        else
        begin
            $display("%0d mismatches, %0d unexpected results", mismatches, unexpected);
            $display("quaternion_to_euler_tb: FAIL");
        end
        $finish;
    end

endmodule
